// ===== src/text_console_writer_macros.svh =====
// Assertion macros for the text console writer.
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

`ifndef SYNTHESIS

// Property holds at every edge outside reset.
`define TCW_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle implies a result in the next.
`define TCW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define TCW_ASSERT(lbl, clk, rst_n, prop, msg)
`define TCW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== src/tcw_pkg.sv =====
// Shared types and constants of the text console writer.
package tcw_pkg;

	localparam int DEF_MAX_COLS = 128;
	localparam int DEF_MAX_ROWS = 32;

	localparam int COLUMNS_RST = 80;
	localparam int ROWS_RST    = 25;

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	// register index, taken from paddr[2]
	localparam logic REG_COLUMNS = 1'b0;
	localparam logic REG_ROWS    = 1'b1;

	localparam logic [1:0] OP_PUT   = 2'd0;
	localparam logic [1:0] OP_SET   = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;
	localparam logic [1:0] OP_READ  = 2'd3;

	localparam logic [7:0] CH_CR  = 8'd13;
	localparam logic [7:0] CH_LF  = 8'd10;
	localparam logic [7:0] CH_BS  = 8'd8;
	localparam logic [7:0] CH_NUL = 8'd0;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] char_code;
		logic [6:0] col;
		logic [4:0] row;
	} tcw_cmd_t;

	typedef struct packed {
		logic [7:0] cell_value;
		logic [6:0] cursor_col;
		logic [4:0] cursor_row;
		logic       scrolled;
	} tcw_rsp_t;

endpackage

// ===== src/text_console_writer.sv =====
// Text console writer: character grid memory, cursor and command sequencer.
//
//  channel | direction | handshake              | word
//  --------+-----------+------------------------+-----------------------------
//  cmd     | in        | cmd_valid / cmd_ready  | opcode, char_code, col, row
//  rsp     | out       | rsp_valid / rsp_ready  | cell_value, cursor, scrolled
//  apb     | in        | psel / penable / pready| columns (0x0), rows (0x4)
//
// Put and read pass through execute, address multiply, memory access and result register
// before their result; set cursor goes from execute straight to the result register.
// cmd_ready returns when the result is registered. A scroll walks columns*rows cells
// (limited sizes), one cell copied per cycle through the memory's read and write ports.
// Clear screen and reset both sweep the whole grid to zero; after reset the sweep ends
// before cmd_ready rises. A stalled rsp word holds the block only when a new result
// is ready to load; the next command is accepted meanwhile.

`include "text_console_writer_macros.svh"

module text_console_writer
	import tcw_pkg::*;
#(
	parameter int MAX_COLS = DEF_MAX_COLS,
	parameter int MAX_ROWS = DEF_MAX_ROWS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  tcw_cmd_t          cmd,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output tcw_rsp_t          rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	localparam int CELLS  = MAX_COLS * MAX_ROWS;
	localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int NCOL_W = $clog2(MAX_COLS + 1);
	localparam int NROW_W = $clog2(MAX_ROWS + 1);
	localparam int PW     = NCOL_W + NROW_W + 1;

	localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
	localparam logic [NCOL_W-1:0] W_RST =
		NCOL_W'((COLUMNS_RST > MAX_COLS) ? MAX_COLS : COLUMNS_RST);
	localparam logic [NROW_W-1:0] H_RST =
		NROW_W'((ROWS_RST > MAX_ROWS) ? MAX_ROWS : ROWS_RST);

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_EXEC   = 3'd2;
	localparam logic [2:0] ST_ADDR   = 3'd3;
	localparam logic [2:0] ST_MEM    = 3'd4;
	localparam logic [2:0] ST_SCROLL = 3'd5;
	localparam logic [2:0] ST_DRAIN  = 3'd6;
	localparam logic [2:0] ST_FIN    = 3'd7;

	logic [7:0] grid_mem [CELLS];
	logic [7:0] rdata_q;

	logic [2:0]        state_q;
	logic [7:0]        columns_q;
	logic [5:0]        rows_q;
	logic [NCOL_W-1:0] w_q;
	logic [NROW_W-1:0] h_q;
	logic [COL_W-1:0]  cur_col_q;
	logic [ROW_W-1:0]  cur_row_q;

	logic [1:0]        op_q;
	logic [7:0]        ch_q;
	logic [COL_W-1:0]  ic_q;
	logic [ROW_W-1:0]  ir_q;
	logic [COL_W-1:0]  tc_q;
	logic [ROW_W-1:0]  tr_q;
	logic              wr_q;
	logic [7:0]        wdata_q;
	logic              scroll_q;
	logic              clr_op_q;
	logic [ADDR_W-1:0] addr_q;
	logic [ADDR_W-1:0] clr_q;
	logic [ADDR_W-1:0] s_q;
	logic [ADDR_W-1:0] lim_q;
	logic [ADDR_W-1:0] last_q;

	logic              act_s1;
	logic              copy_s1;
	logic [ADDR_W-1:0] wa_s1;

	logic              rsp_valid_q;
	tcw_rsp_t          rsp_q;

	logic [COL_W-1:0]  w_m1;
	logic [ROW_W-1:0]  h_m1;
	logic [NCOL_W-1:0] cfg_w;
	logic [NROW_W-1:0] cfg_h;
	logic              cfg_wr;
	logic              cmd_acc;
	logic              rsp_load;

	logic [COL_W:0]    c_inc;
	logic [ROW_W:0]    r_inc;
	logic [COL_W-1:0]  ex_col;
	logic [ROW_W:0]    ex_row_w;
	logic [ROW_W-1:0]  ex_row;
	logic [COL_W-1:0]  ex_tc;
	logic [ROW_W-1:0]  ex_tr;
	logic              ex_wr;
	logic [7:0]        ex_wd;
	logic              ex_scr;

	logic              mem_we;
	logic [ADDR_W-1:0] mem_wa;
	logic [7:0]        mem_wd;
	logic [ADDR_W-1:0] mem_ra;

	assign pready    = 1'b1;
	assign cmd_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign cmd_acc   = cmd_valid && cmd_ready;
	assign rsp_load  = (state_q == ST_FIN) && (!rsp_valid_q || rsp_ready);
	assign cfg_wr    = psel && penable && pwrite;

	assign w_m1 = COL_W'(w_q - 1'b1);
	assign h_m1 = ROW_W'(h_q - 1'b1);

	// register limits are saturated once, on write
	assign cfg_w = (pwdata[7:0] == 8'd0) ? NCOL_W'(1) :
		((pwdata[7:0] > MAX_COLS) ? NCOL_W'(MAX_COLS) : NCOL_W'(pwdata[7:0]));
	assign cfg_h = (pwdata[5:0] == 6'd0) ? NROW_W'(1) :
		((pwdata[5:0] > MAX_ROWS) ? NROW_W'(MAX_ROWS) : NROW_W'(pwdata[5:0]));

	always_comb begin
		unique case (paddr[2])
			REG_COLUMNS: prdata = {{(APB_DW-8){1'b0}}, columns_q};
			REG_ROWS:    prdata = {{(APB_DW-6){1'b0}}, rows_q};
		endcase
	end

	// next cursor and target cell of the accepted word
	always_comb begin
		c_inc    = {1'b0, cur_col_q} + 1'b1;
		r_inc    = {1'b0, cur_row_q} + 1'b1;
		ex_col   = cur_col_q;
		ex_row_w = {1'b0, cur_row_q};
		ex_tc    = cur_col_q;
		ex_tr    = cur_row_q;
		ex_wr    = 1'b0;
		ex_wd    = ch_q;
		unique case (op_q)
			OP_PUT: begin
				case (ch_q) inside
					CH_CR, CH_LF: begin
						ex_col   = '0;
						ex_row_w = r_inc;
					end
					CH_BS: begin
						if (cur_col_q == '0 && cur_row_q == '0) begin
							ex_wr = 1'b0;
						end else if (cur_col_q == '0) begin
							ex_col   = w_m1;
							ex_row_w = {1'b0, cur_row_q} - 1'b1;
							ex_tc    = w_m1;
							ex_tr    = cur_row_q - 1'b1;
							ex_wr    = 1'b1;
							ex_wd    = CH_NUL;
						end else begin
							ex_col = cur_col_q - 1'b1;
							ex_tc  = cur_col_q - 1'b1;
							ex_wr  = 1'b1;
							ex_wd  = CH_NUL;
						end
					end
					default: begin
						ex_wr = 1'b1;
						if (c_inc >= w_q) begin
							ex_col   = '0;
							ex_row_w = r_inc;
						end else begin
							ex_col = COL_W'(c_inc);
						end
					end
				endcase
			end
			OP_SET: begin
				ex_col   = ic_q;
				ex_row_w = {1'b0, ir_q};
			end
			OP_CLEAR: begin
				ex_col   = '0;
				ex_row_w = '0;
			end
			OP_READ: begin
				ex_tc = ic_q;
				ex_tr = ir_q;
			end
		endcase
		ex_scr = (op_q == OP_PUT) && (ex_row_w >= h_q);
		ex_row = ex_scr ? h_m1 : ROW_W'(ex_row_w);
	end

	// memory port selection
	always_comb begin
		mem_we = 1'b0;
		mem_wa = addr_q;
		mem_wd = wdata_q;
		if (state_q == ST_CLEAR) begin
			mem_we = 1'b1;
			mem_wa = clr_q;
			mem_wd = CH_NUL;
		end else if (act_s1) begin
			mem_we = 1'b1;
			mem_wa = wa_s1;
			mem_wd = copy_s1 ? rdata_q : CH_NUL;
		end else if (state_q == ST_MEM && wr_q) begin
			mem_we = 1'b1;
		end
		mem_ra = (state_q == ST_SCROLL) ? ADDR_W'(PW'(s_q) + PW'(w_q)) : addr_q;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			grid_mem[mem_wa] <= mem_wd;
		end
		rdata_q <= grid_mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			columns_q   <= 8'(COLUMNS_RST);
			rows_q      <= 6'(ROWS_RST);
			w_q         <= W_RST;
			h_q         <= H_RST;
			cur_col_q   <= '0;
			cur_row_q   <= '0;
			clr_q       <= '0;
			clr_op_q    <= 1'b0;
			act_s1      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			// read lands next cycle, written one row up
			act_s1 <= (state_q == ST_SCROLL);
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_wr) begin
				unique case (paddr[2])
					REG_COLUMNS: begin
						columns_q <= pwdata[7:0];
						w_q       <= cfg_w;
					end
					REG_ROWS: begin
						rows_q <= pwdata[5:0];
						h_q    <= cfg_h;
					end
				endcase
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (clr_q == LAST_CELL) begin
						clr_q   <= '0;
						state_q <= clr_op_q ? ST_FIN : ST_IDLE;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (cmd_acc) begin
						op_q      <= cmd.opcode;
						ch_q      <= cmd.char_code;
						ic_q      <= (cmd.col >= w_q) ? w_m1 : COL_W'(cmd.col);
						ir_q      <= (cmd.row >= h_q) ? h_m1 : ROW_W'(cmd.row);
						cur_col_q <= (cur_col_q >= w_q) ? w_m1 : cur_col_q;
						cur_row_q <= (cur_row_q >= h_q) ? h_m1 : cur_row_q;
						scroll_q  <= 1'b0;
						wr_q      <= 1'b0;
						state_q   <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					cur_col_q <= ex_col;
					cur_row_q <= ex_row;
					tc_q      <= ex_tc;
					tr_q      <= ex_tr;
					wr_q      <= ex_wr;
					wdata_q   <= ex_wd;
					scroll_q  <= ex_scr;
					unique case (op_q)
						OP_SET:   state_q <= ST_FIN;
						OP_CLEAR: begin
							clr_q    <= '0;
							clr_op_q <= 1'b1;
							state_q  <= ST_CLEAR;
						end
						OP_PUT, OP_READ: state_q <= ST_ADDR;
					endcase
				end
				ST_ADDR: begin
					addr_q  <= ADDR_W'(PW'(tr_q) * PW'(w_q) + PW'(tc_q));
					lim_q   <= ADDR_W'(PW'(h_q) * PW'(w_q) - PW'(w_q));
					state_q <= ST_MEM;
				end
				ST_MEM: begin
					s_q     <= '0;
					last_q  <= ADDR_W'(PW'(lim_q) + PW'(w_q) - PW'(1));
					state_q <= scroll_q ? ST_SCROLL : ST_FIN;
				end
				ST_SCROLL: begin
					wa_s1   <= s_q;
					copy_s1 <= (s_q < lim_q);
					s_q     <= s_q + 1'b1;
					if (s_q == last_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (rsp_load) begin
						rsp_q.cell_value <= (op_q == OP_READ) ? rdata_q : CH_NUL;
						rsp_q.cursor_col <= 7'(cur_col_q);
						rsp_q.cursor_row <= 5'(cur_row_q);
						rsp_q.scrolled   <= scroll_q;
						clr_op_q         <= 1'b0;
						state_q          <= ST_IDLE;
					end
				end
			endcase
		end
	end

	`TCW_ASSERT(a_s1_scroll, clk, arst_n, act_s1 == ($past(state_q) == ST_SCROLL), "stray copy")
	`TCW_ASSERT_NEXT(a_clr_end, clk, arst_n, clr_q == LAST_CELL, clr_q == '0, "sweep overran")
	`TCW_ASSERT(a_scroll_put, clk, arst_n, state_q != ST_SCROLL || op_q == OP_PUT, "bad scroll")
	`TCW_ASSERT(a_rsp_src, clk, arst_n, !$rose(rsp_valid) || $past(state_q) == ST_FIN, "bad rsp")

endmodule

// ===== test/text_console_writer_test.sv =====
// Self-checking testbench for the text console writer: directed table, then random phases.
`timescale 1ns / 100ps

module text_console_writer_test;
	import tcw_pkg::*;

	localparam int HALF_PERIOD = 5;
	localparam int GRID_W = DEF_MAX_COLS;
	localparam int GRID_H = DEF_MAX_ROWS;
	localparam int GRID_CELLS = GRID_W * GRID_H;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int MAX_REPORTS = 200;
	localparam int NUM_FIXED = 5;
	localparam int NUM_RANDOM = 10;

	// one directed row: command word, whether the result is typed in, and that result
	typedef struct packed {
		tcw_cmd_t word;
		logic     pinned;
		tcw_rsp_t rsp;
	} step_t;

	// defaults 80 x 25, grid clear, cursor at the origin
	localparam step_t PLAN [25] = '{
		{OP_READ,  8'h00,  7'd0,   5'd0,  1'b1, 8'h00, 7'd0,  5'd0,  1'b0},
		{OP_READ,  8'hFF,  7'd127, 5'd31, 1'b1, 8'h00, 7'd0,  5'd0,  1'b0},
		{OP_PUT,   CH_BS,  7'd0,   5'd0,  1'b1, 8'h00, 7'd0,  5'd0,  1'b0},
		{OP_PUT,   8'h41,  7'd0,   5'd0,  1'b1, 8'h00, 7'd1,  5'd0,  1'b0},
		{OP_PUT,   8'hFF,  7'd127, 5'd31, 1'b1, 8'h00, 7'd2,  5'd0,  1'b0},
		{OP_PUT,   CH_NUL, 7'd0,   5'd0,  1'b1, 8'h00, 7'd3,  5'd0,  1'b0},
		{OP_READ,  8'h00,  7'd1,   5'd0,  1'b1, 8'hFF, 7'd3,  5'd0,  1'b0},
		{OP_PUT,   CH_CR,  7'd0,   5'd0,  1'b1, 8'h00, 7'd0,  5'd1,  1'b0},
		{OP_PUT,   CH_BS,  7'd0,   5'd0,  1'b1, 8'h00, 7'd79, 5'd0,  1'b0},
		{OP_READ,  8'h00,  7'd79,  5'd0,  1'b0, 21'd0},
		{OP_PUT,   CH_LF,  7'd0,   5'd0,  1'b1, 8'h00, 7'd0,  5'd1,  1'b0},
		{OP_SET,   8'h00,  7'd127, 5'd31, 1'b1, 8'h00, 7'd79, 5'd24, 1'b0},
		{OP_PUT,   8'h5A,  7'd0,   5'd0,  1'b1, 8'h00, 7'd0,  5'd24, 1'b1},
		{OP_READ,  8'h00,  7'd79,  5'd23, 1'b0, 21'd0},
		{OP_READ,  8'h00,  7'd1,   5'd0,  1'b0, 21'd0},
		{OP_PUT,   CH_LF,  7'd0,   5'd0,  1'b1, 8'h00, 7'd0,  5'd24, 1'b1},
		{OP_READ,  8'h00,  7'd79,  5'd22, 1'b0, 21'd0},
		{OP_SET,   8'h00,  7'd5,   5'd3,  1'b1, 8'h00, 7'd5,  5'd3,  1'b0},
		{OP_PUT,   8'h80,  7'd0,   5'd0,  1'b0, 21'd0},
		{OP_PUT,   8'h7F,  7'd0,   5'd0,  1'b0, 21'd0},
		{OP_PUT,   CH_BS,  7'd0,   5'd0,  1'b0, 21'd0},
		{OP_READ,  8'h00,  7'd5,   5'd3,  1'b0, 21'd0},
		{OP_READ,  8'h00,  7'd6,   5'd3,  1'b0, 21'd0},
		{OP_CLEAR, 8'hAA,  7'h55,  5'h15, 1'b1, 8'h00, 7'd0,  5'd0,  1'b0},
		{OP_READ,  8'h00,  7'd5,   5'd3,  1'b1, 8'h00, 7'd0,  5'd0,  1'b0}
	};

	// fixed settings first: extremes, out-of-range values, the long hold-off phase
	localparam int FIX_COLS [NUM_FIXED] = '{1, 0, 128, 4, 255};
	localparam int FIX_ROWS [NUM_FIXED] = '{1, 0, 32, 3, 63};
	localparam int FIX_WORDS [NUM_FIXED] = '{60, 60, 40, 150, 30};
	localparam int HOLD_PHASE = 3;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cmd_valid = 1'b0;
	logic                cmd_ready;
	tcw_cmd_t            cmd = '0;
	logic                rsp_valid;
	logic                rsp_ready = 1'b0;
	tcw_rsp_t            rsp;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [APB_AW-1:0]   paddr = '0;
	logic [APB_DW-1:0]   pwdata = '0;
	logic [APB_DW-1:0]   prdata;
	logic                pready;

	// typed-in expectation travelling with the word on offer
	logic                pinned = 1'b0;
	tcw_rsp_t            pinned_rsp = '0;

	logic [7:0]          screen [GRID_CELLS];
	int                  cursor_c = 0;
	int                  cursor_r = 0;
	logic [7:0]          width_reg = 8'(COLUMNS_RST);
	logic [5:0]          height_reg = 6'(ROWS_RST);
	tcw_rsp_t            rsp_due_q [$];
	int                  err_count = 0;
	int                  burst_left = 0;
	bit                  hold_req = 1'b0;

	text_console_writer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always #HALF_PERIOD clk = ~clk;

	task automatic report_mismatch(string what);
		err_count++;
		if (err_count <= MAX_REPORTS) $display("%0t ns: %s", $time, what);
	endtask

	function automatic int width_eff();
		if (width_reg == 0) return 1;
		return (width_reg > GRID_W) ? GRID_W : int'(width_reg);
	endfunction

	function automatic int height_eff();
		if (height_reg == 0) return 1;
		return (height_reg > GRID_H) ? GRID_H : int'(height_reg);
	endfunction

	// applies one command to the screen copy and returns the result word it gives
	function automatic tcw_rsp_t screen_update(tcw_cmd_t c);
		int w;
		int h;
		int cc;
		int cr;
		tcw_rsp_t r;
		w = width_eff();
		h = height_eff();
		r = '0;
		if (cursor_c >= w) cursor_c = w - 1;
		if (cursor_r >= h) cursor_r = h - 1;
		cc = (c.col >= w) ? w - 1 : int'(c.col);
		cr = (c.row >= h) ? h - 1 : int'(c.row);
		case (c.opcode)
			OP_PUT: begin
				if (c.char_code == CH_CR || c.char_code == CH_LF) begin
					cursor_c = 0;
					cursor_r++;
				end else if (c.char_code == CH_BS) begin
					// nothing to rub out at the origin
					if (cursor_c != 0 || cursor_r != 0) begin
						if (cursor_c == 0) begin
							cursor_c = w - 1;
							cursor_r--;
						end else begin
							cursor_c--;
						end
						screen[cursor_r * w + cursor_c] = CH_NUL;
					end
				end else begin
					screen[cursor_r * w + cursor_c] = c.char_code;
					cursor_c++;
					if (cursor_c >= w) begin
						cursor_c = 0;
						cursor_r++;
					end
				end
				if (cursor_r >= h) begin
					cursor_r = h - 1;
					for (int i = 0; i < w * (h - 1); i++) screen[i] = screen[i + w];
					for (int i = w * (h - 1); i < w * h; i++) screen[i] = CH_NUL;
					r.scrolled = 1'b1;
				end
			end
			OP_SET: begin
				cursor_c = cc;
				cursor_r = cr;
			end
			OP_CLEAR: begin
				foreach (screen[i]) screen[i] = CH_NUL;
				cursor_c = 0;
				cursor_r = 0;
			end
			default: r.cell_value = screen[cr * w + cc];
		endcase
		r.cursor_col = 7'(cursor_c);
		r.cursor_row = 5'(cursor_r);
		return r;
	endfunction

	function automatic tcw_cmd_t random_word();
		tcw_cmd_t c;
		int pick;
		int w;
		int h;
		w = width_eff();
		h = height_eff();
		pick = $urandom_range(0, 199);
		c.char_code = 8'($urandom_range(0, 255));
		// mostly near the grid, sometimes anywhere in the field
		c.col = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
			: 7'($urandom_range(0, (w > 127) ? 127 : w));
		c.row = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
			: 5'($urandom_range(0, (h > 31) ? 31 : h));
		if (pick < 3) begin
			c.opcode = OP_CLEAR;
		end else if (pick < 35) begin
			c.opcode = OP_SET;
		end else if (pick < 90) begin
			c.opcode = OP_READ;
		end else begin
			c.opcode = OP_PUT;
			case ($urandom_range(0, 9))
				0: c.char_code = CH_CR;
				1: c.char_code = CH_LF;
				2, 3: c.char_code = CH_BS;
				default: ;
			endcase
		end
		return c;
	endfunction

	// accept side predicts, return side compares against the oldest prediction
	always @(posedge clk) begin : scoreboard
		tcw_rsp_t due;
		if (cmd_valid && cmd_ready) begin
			due = screen_update(cmd);
			if (pinned) due = pinned_rsp;
			rsp_due_q.push_back(due);
		end
		if (rsp_valid && rsp_ready) begin
			if (rsp_due_q.size() == 0) begin
				report_mismatch($sformatf("result word %h with none due", rsp));
			end else begin
				due = rsp_due_q.pop_front();
				if (rsp.cell_value !== due.cell_value || rsp.cursor_col !== due.cursor_col ||
						rsp.cursor_row !== due.cursor_row || rsp.scrolled !== due.scrolled)
					report_mismatch($sformatf(
						"cell %h/%h col %0d/%0d row %0d/%0d scrolled %b/%b (got/exp)",
						rsp.cell_value, due.cell_value, rsp.cursor_col, due.cursor_col,
						rsp.cursor_row, due.cursor_row, rsp.scrolled, due.scrolled));
			end
		end
	end

	// receiver: stall pattern changes at random intervals, long hold-off on request
	initial begin : result_sink
		int mode;
		int left;
		mode = 0;
		left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				rsp_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end else begin
				if (left == 0) begin
					mode = $urandom_range(0, 3);
					left = $urandom_range(8, 64);
				end
				left--;
				case (mode)
					0: rsp_ready <= 1'b1;
					1: rsp_ready <= 1'($urandom_range(0, 1));
					2: rsp_ready <= ($urandom_range(0, 3) == 0);
					default: rsp_ready <= ((left % 8) < 5);
				endcase
			end
		end
	end

	task automatic offer_word(tcw_cmd_t w, logic pin, tcw_rsp_t pin_val);
		cmd_valid <= 1'b1;
		cmd <= w;
		pinned <= pin;
		pinned_rsp <= pin_val;
		do @(posedge clk); while (!cmd_ready);
	endtask

	// bursts of random length, random gap between bursts
	task automatic sender_pace();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				cmd_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic await_results();
		cmd_valid <= 1'b0;
		do @(posedge clk); while (rsp_due_q.size() != 0);
	endtask

	// write one register, then read it back
	task automatic reg_write(logic idx, logic [7:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_AW'({idx, 2'b00});
		pwdata <= APB_DW'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == REG_COLUMNS) width_reg = value;
		else height_reg = value[5:0];
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== APB_DW'(value))
			report_mismatch($sformatf("register %0d reads %h, written %h", idx, prdata, value));
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	initial begin : stimulus
		int words;
		int cols_set;
		int rows_set;
		foreach (screen[i]) screen[i] = CH_NUL;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		foreach (PLAN[i]) begin
			sender_pace();
			offer_word(PLAN[i].word, PLAN[i].pinned, PLAN[i].rsp);
		end
		await_results();

		for (int p = 0; p < NUM_FIXED + NUM_RANDOM; p++) begin
			if (p < NUM_FIXED) begin
				cols_set = FIX_COLS[p];
				rows_set = FIX_ROWS[p];
				words = FIX_WORDS[p];
			end else begin
				cols_set = $urandom_range(1, 16);
				rows_set = $urandom_range(1, 8);
				words = $urandom_range(110, 170);
			end
			reg_write(REG_COLUMNS, 8'(cols_set));
			reg_write(REG_ROWS, 8'(rows_set));
			if (p == HOLD_PHASE) hold_req = 1'b1;
			repeat (words) begin
				sender_pace();
				offer_word(random_word(), 1'b0, '0);
			end
			await_results();
		end

		repeat (64) @(posedge clk);
		if (err_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin : watchdog
		#50_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
